@@ src/ahsp_pkg.sv @@
`default_nettype none
package ahsp_pkg;

	// Result kinds
	localparam logic [1:0] KIND_FIELD = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Field codes that the parser treats specially
	localparam logic [5:0] FC_VER_MAJOR   = 6'd0;
	localparam logic [5:0] FC_VER_MINOR   = 6'd1;
	localparam logic [5:0] FC_DATA_OFFSET = 6'd2;
	localparam logic [5:0] FC_BLOCK_COUNT = 6'd5;
	localparam logic [5:0] FC_COMP_BLOCK  = 6'd8;
	localparam logic [5:0] FC_DEC_BLOCK   = 6'd18;
	localparam logic [5:0] FC_DEC_TRACKS  = 6'd23;
	localparam logic [5:0] FC_DEC_CHCFG   = 6'd24;
	localparam logic [5:0] FC_NONE        = 6'h3F;

	// Magic word after masking each byte to seven bits
	localparam logic [31:0] MAGIC_WORD = 32'h4843_4100;
	localparam logic [7:0]  TAG_MASK   = 8'h7F;
	localparam logic [7:0]  NIBBLE     = 8'h0F;

	// Section kinds
	localparam logic [3:0] SK_NONE = 4'd0;
	localparam logic [3:0] SK_DEC  = 4'd3;
	localparam logic [3:0] DEC_SPLIT_OFFSET = 4'd6;

	localparam logic [31:0] TAG_WORDS [0:8] = '{
		32'h0000_0000, 32'h666d_7400, 32'h636f_6d70, 32'h6465_6300, 32'h7662_7200,
		32'h6174_6800, 32'h6c6f_6f70, 32'h6369_7068, 32'h7276_6100
	};

	localparam logic [3:0] SECT_LEN [0:8] = '{
		4'd0, 4'd12, 4'd12, 4'd8, 4'd4, 4'd2, 4'd12, 4'd2, 4'd4
	};

	localparam logic [5:0] SECT_CODE [0:8][0:11] = '{
		'{6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
		'{6'd3,  6'h3F, 6'h3F, 6'd4,  6'h3F, 6'h3F, 6'h3F, 6'd5,  6'h3F, 6'd6,  6'h3F, 6'd7},
		'{6'h3F, 6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'h3F, 6'd17},
		'{6'h3F, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd25, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
		'{6'h3F, 6'd26, 6'h3F, 6'd27, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
		'{6'h3F, 6'd28, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
		'{6'h3F, 6'h3F, 6'h3F, 6'd29, 6'h3F, 6'h3F, 6'h3F, 6'd30, 6'h3F, 6'd31, 6'h3F, 6'd32},
		'{6'h3F, 6'd33, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
		'{6'h3F, 6'h3F, 6'h3F, 6'd34, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F}
	};

	// Everything one byte causes, handed from the parser to the result side
	typedef struct packed {
		logic        err;
		logic        fld;
		logic        split;
		logic [5:0]  code;
		logic [31:0] value;
		logic        fin;
		logic [31:0] size;
	} rec_t;

	// Section kind of a tag word, none when unknown
	function automatic logic [3:0] tag_kind(input logic [31:0] word);
		logic [3:0] k;
		k = SK_NONE;
		for (int i = 1; i < 9; i++) begin
			if (TAG_WORDS[i] == word) begin
				k = 4'(i);
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

@@ src/ahsp_front.sv @@
`default_nettype none
module ahsp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              frame_start,
	output ahsp_pkg::rec_t         rec,
	output logic                   rec_valid
);

	typedef enum logic [2:0] {
		PH_MAGIC, PH_HEAD, PH_TAG, PH_SECT, PH_DONE
	} phase_t;

	phase_t      ph_q, c_ph, n_ph;
	logic [31:0] pos_q, c_pos, n_pos, pos_inc;
	logic [1:0]  ts_q, c_ts, n_ts;
	logic [3:0]  sk_q, c_sk, n_sk;
	logic [3:0]  so_q, c_so, n_so;
	logic [31:0] acc_q, c_acc, n_acc, acc_sh, acc_m;
	logic [15:0] hdo_q, c_hdo, n_hdo;
	logic        cs_q, c_cs, n_cs;
	logic        ds_q, c_ds, n_ds;
	logic [31:0] tb_q, c_tb, n_tb;
	logic [15:0] cbb_q, c_cbb, n_cbb;
	logic [15:0] dbb_q, c_dbb, n_dbb;
	logic [31:0] prod_q;
	logic [15:0] bs_sel;
	logic [31:0] bound;
	logic [5:0]  code;
	logic [3:0]  kind;
	logic        chk;
	ahsp_pkg::rec_t r;

	// Block size chosen for the end result; the product is kept registered
	always_comb begin
		bs_sel = cs_q ? cbb_q : (ds_q ? dbb_q : 16'd0);
	end

	// Parse one byte: a frame start parses from the reset state
	always_comb begin
		c_ph  = frame_start ? PH_MAGIC : ph_q;
		c_pos = frame_start ? 32'd0 : pos_q;
		c_ts  = frame_start ? 2'd0 : ts_q;
		c_sk  = frame_start ? ahsp_pkg::SK_NONE : sk_q;
		c_so  = frame_start ? 4'd0 : so_q;
		c_acc = frame_start ? 32'd0 : acc_q;
		c_hdo = frame_start ? 16'd0 : hdo_q;
		c_cs  = frame_start ? 1'b0 : cs_q;
		c_ds  = frame_start ? 1'b0 : ds_q;
		c_tb  = frame_start ? 32'd0 : tb_q;
		c_cbb = frame_start ? 16'd0 : cbb_q;
		c_dbb = frame_start ? 16'd0 : dbb_q;
		n_ph = c_ph; n_pos = c_pos; n_ts = c_ts; n_sk = c_sk; n_so = c_so;
		n_acc = c_acc; n_hdo = c_hdo; n_cs = c_cs; n_ds = c_ds; n_tb = c_tb;
		n_cbb = c_cbb; n_dbb = c_dbb;
		r = '0;
		chk = 1'b0;
		pos_inc = c_pos + 32'd1;
		acc_sh = {c_acc[23:0], data_byte};
		acc_m = {c_acc[23:0], data_byte & ahsp_pkg::TAG_MASK};
		kind = c_sk;
		code = ahsp_pkg::SECT_CODE[c_sk][c_so];
		unique case (c_ph)
			PH_MAGIC: begin
				n_acc = acc_m;
				n_pos = pos_inc;
				if (pos_inc >= 32'd4) begin
					n_acc = '0;
					if (acc_m != ahsp_pkg::MAGIC_WORD) begin
						r.err = 1'b1;
						n_ph = PH_DONE;
					end else begin
						n_ph = PH_HEAD;
					end
				end
			end
			PH_HEAD: begin
				n_pos = pos_inc;
				if (c_pos == 32'd4) begin
					r.fld = 1'b1;
					r.code = ahsp_pkg::FC_VER_MAJOR;
					r.value = {24'd0, data_byte};
				end else if (c_pos == 32'd5) begin
					r.fld = 1'b1;
					r.code = ahsp_pkg::FC_VER_MINOR;
					r.value = {24'd0, data_byte};
				end else if (c_pos == 32'd6) begin
					n_acc = {24'd0, data_byte};
				end else begin
					n_hdo = {c_acc[7:0], data_byte};
					n_acc = '0;
					r.fld = 1'b1;
					r.code = ahsp_pkg::FC_DATA_OFFSET;
					r.value = {16'd0, c_acc[7:0], data_byte};
				end
				if (pos_inc >= 32'd8) begin
					n_ph = PH_TAG;
					n_ts = 2'd0;
					chk = 1'b1;
				end
			end
			PH_TAG: begin
				n_acc = acc_m;
				n_pos = pos_inc;
				n_ts = c_ts + 2'd1;
				if (c_ts == 2'd3) begin
					n_acc = '0;
					if (acc_m == 32'd0) begin
						// A zero tag always ends the header
						r.fin = 1'b1;
						n_ph = PH_DONE;
					end else begin
						kind = ahsp_pkg::tag_kind(acc_m);
						n_sk = kind;
						if (kind != ahsp_pkg::SK_NONE) begin
							n_ph = PH_SECT;
							n_so = 4'd0;
						end else begin
							chk = 1'b1;
						end
					end
				end
			end
			PH_SECT: begin
				n_acc = acc_sh;
				n_pos = pos_inc;
				if (c_sk == ahsp_pkg::SK_DEC && c_so == ahsp_pkg::DEC_SPLIT_OFFSET) begin
					// Tracks and channel config share one byte
					r.fld = 1'b1;
					r.split = 1'b1;
					r.code = ahsp_pkg::FC_DEC_TRACKS;
					r.value = {24'd0, data_byte};
					n_acc = '0;
				end else if (code != ahsp_pkg::FC_NONE) begin
					r.fld = 1'b1;
					r.code = code;
					r.value = acc_sh;
					n_acc = '0;
					if (code == ahsp_pkg::FC_BLOCK_COUNT) begin
						n_tb = acc_sh;
					end else if (code == ahsp_pkg::FC_COMP_BLOCK) begin
						n_cbb = acc_sh[15:0];
						n_cs = 1'b1;
					end else if (code == ahsp_pkg::FC_DEC_BLOCK) begin
						n_dbb = acc_sh[15:0];
						n_ds = 1'b1;
					end
				end
				n_so = c_so + 4'd1;
				if (n_so >= ahsp_pkg::SECT_LEN[c_sk]) begin
					n_so = 4'd0;
					n_sk = ahsp_pkg::SK_NONE;
					n_ph = PH_TAG;
					chk = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		// End when the next tag would start at or past data offset minus two
		bound = {16'd0, n_hdo} - 32'd2;
		if (chk && n_pos >= bound) begin
			r.fin = 1'b1;
			n_ph = PH_DONE;
		end
		r.size = r.fin ? ({16'd0, n_hdo} + prod_q) : 32'd0;
	end

	assign rec = r;
	assign rec_valid = accept && (r.err || r.fld || r.fin);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_MAGIC;
			pos_q <= '0;
			ts_q <= '0;
			sk_q <= ahsp_pkg::SK_NONE;
			so_q <= '0;
			acc_q <= '0;
			hdo_q <= '0;
			cs_q <= 1'b0;
			ds_q <= 1'b0;
			tb_q <= '0;
			cbb_q <= '0;
			dbb_q <= '0;
			prod_q <= '0;
		end else begin
			prod_q <= 32'(bs_sel) * tb_q;
			if (accept) begin
				ph_q <= n_ph;
				pos_q <= n_pos;
				ts_q <= n_ts;
				sk_q <= n_sk;
				so_q <= n_so;
				acc_q <= n_acc;
				hdo_q <= n_hdo;
				cs_q <= n_cs;
				ds_q <= n_ds;
				tb_q <= n_tb;
				cbb_q <= n_cbb;
				dbb_q <= n_dbb;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/ahsp_fifo.sv @@
`default_nettype none
module ahsp_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  ahsp_pkg::rec_t wr_data,
	input  wire logic      rd_en,
	output ahsp_pkg::rec_t rd_data,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	ahsp_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == FULLC);
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	// Storage for waiting words
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/ahsp_back.sv @@
`default_nettype none
module ahsp_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  ahsp_pkg::rec_t   q_data,
	input  wire logic        q_empty,
	output logic             q_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       result_kind,
	output logic [5:0]       field_code,
	output logic [31:0]      field_value,
	output logic [31:0]      file_size,
	output logic             last
);

	// Pending results of the held record: error, field, second field, end
	ahsp_pkg::rec_t cur_q;
	logic [3:0] rem_q, rem_after;
	logic take, load;

	assign empty = (rem_q == 4'd0);
	assign take = pop && !empty;
	assign rem_after = rem_q & (rem_q - 4'd1);
	assign last = !empty && (rem_after == 4'd0);
	assign load = empty || (take && rem_after == 4'd0);
	assign q_pop = load && !q_empty;

	// Present the oldest pending result of the held record
	always_comb begin
		result_kind = ahsp_pkg::KIND_FIELD;
		field_code = '0;
		field_value = '0;
		file_size = '0;
		priority if (rem_q[0]) begin
			result_kind = ahsp_pkg::KIND_ERROR;
		end else if (rem_q[1]) begin
			field_code = cur_q.code;
			field_value = cur_q.split ? {28'd0, cur_q.value[7:4]} : cur_q.value;
		end else if (rem_q[2]) begin
			field_code = ahsp_pkg::FC_DEC_CHCFG;
			field_value = {24'd0, cur_q.value[7:0] & ahsp_pkg::NIBBLE};
		end else if (rem_q[3]) begin
			result_kind = ahsp_pkg::KIND_END;
			file_size = cur_q.size;
		end else begin
			result_kind = ahsp_pkg::KIND_FIELD;
		end
	end

	// Held record
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= q_empty ? 4'd0 : {q_data.fin, q_data.split, q_data.fld, q_data.err};
		end else if (take) begin
			rem_q <= rem_after;
		end
	end

endmodule
`default_nettype wire

@@ src/audio_header_section_parser_top.sv @@
`default_nettype none
// Header parser for a tagged audio container, one header byte per word and one
// word per cycle. Each accepted byte is parsed in the cycle it arrives; the
// words it causes (at most two: a field, a split pair, an error or an end word,
// or a field then an end word) wait in a queue of QUEUE_DEPTH records and leave
// one per cycle while pop is high, each via the held record register. Input
// is refused only when that queue is full, so bytes are taken one a cycle while
// results are taken and the bytes cause no more words than there are cycles; a
// byte that causes two words holds the result side until both are taken. A byte
// with frame_start high restarts the parser; after an end or error word later
// bytes are accepted and ignored until the next frame start.
module audio_header_section_parser_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_start,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       result_kind,
	output logic [5:0]       field_code,
	output logic [31:0]      field_value,
	output logic [31:0]      file_size,
	output logic             last
);

	ahsp_pkg::rec_t rec, q_data;
	logic rec_valid, accept, q_empty, q_pop;

	assign accept = push && !full;

	ahsp_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .data_byte(data_byte),
		.frame_start(frame_start), .rec(rec), .rec_valid(rec_valid)
	);

	ahsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(rec_valid), .wr_data(rec),
		.rd_en(q_pop), .rd_data(q_data), .full(full), .empty(q_empty)
	);

	ahsp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
		.pop(pop), .empty(empty), .result_kind(result_kind), .field_code(field_code),
		.field_value(field_value), .file_size(file_size), .last(last)
	);

endmodule
`default_nettype wire

@@ dv/audio_header_section_parser_top_test.sv @@
`default_nettype none
module audio_header_section_parser_top_test;

	localparam int STALL_LIMIT = 2000;
	localparam logic [5:0] NO_CODE = 6'd0;

	typedef enum logic [2:0] {
		P_MAGIC, P_HEAD, P_TAG, P_SECT, P_DONE
	} parse_phase_t;

	typedef struct {
		logic [7:0] b;
		logic       fs;
		bit         drain;
	} hdr_byte_t;

	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  code;
		logic [31:0] value;
		logic [31:0] size;
		logic        last;
	} parse_word_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        frame_start;
	logic        empty;
	logic        pop;
	logic [1:0]  result_kind;
	logic [5:0]  field_code;
	logic [31:0] field_value;
	logic [31:0] file_size;
	logic        last;

	hdr_byte_t   pending_bytes[$];
	parse_word_t expected_words[$];
	int          errors = 0;
	int          cycle = 0;
	int          stall_cycles;

	// Shadow copy of the parser state.
	parse_phase_t ph;
	logic [31:0]  pos;
	logic [31:0]  tag_cnt;
	logic [3:0]   sect;
	logic [3:0]   sect_off;
	logic [31:0]  acc;
	logic [15:0]  data_ofs;
	logic         fmt_seen, comp_seen, dec_seen;
	logic [31:0]  blocks;
	logic [15:0]  comp_bs, dec_bs;

	audio_header_section_parser_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .frame_start(frame_start), .empty(empty), .pop(pop),
		.result_kind(result_kind), .field_code(field_code), .field_value(field_value),
		.file_size(file_size), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit idle_now();
		if (cycle > 100 && cycle < 250) begin
			return 1'b0;
		end
		return $urandom_range(0, 99) < 23;
	endfunction

	task automatic clear_parser();
		ph = P_MAGIC;
		pos = '0;
		tag_cnt = '0;
		sect = ahsp_pkg::SK_NONE;
		sect_off = '0;
		acc = '0;
		data_ofs = '0;
		fmt_seen = 1'b0;
		comp_seen = 1'b0;
		dec_seen = 1'b0;
		blocks = '0;
		comp_bs = '0;
		dec_bs = '0;
	endtask

	task automatic expect_word(input logic [1:0] kind, input logic [5:0] code,
			input logic [31:0] value, input logic [31:0] size);
		expected_words.push_back('{kind, code, value, size, 1'b0});
	endtask

	function automatic logic [31:0] header_file_size();
		logic [31:0] bs;
		bs = comp_seen ? 32'(comp_bs) : (dec_seen ? 32'(dec_bs) : 32'd0);
		return 32'(data_ofs) + bs * blocks;
	endfunction

	// The header ends once the position reaches the data offset less two.
	task automatic check_header_end();
		if (pos >= 32'(data_ofs) - 32'd2) begin
			expect_word(ahsp_pkg::KIND_END, NO_CODE, '0, header_file_size());
			ph = P_DONE;
		end
	endtask

	// Works out every word one accepted byte causes.
	task automatic parse_byte(input logic [7:0] b, input logic fs);
		int          n0;
		logic [31:0] word;
		logic [5:0]  code;
		n0 = expected_words.size();
		if (fs) begin
			clear_parser();
		end
		case (ph)
			P_MAGIC: begin
				acc = (acc << 8) | 32'(b & ahsp_pkg::TAG_MASK);
				pos++;
				if (pos >= 4) begin
					if (acc != ahsp_pkg::MAGIC_WORD) begin
						expect_word(ahsp_pkg::KIND_ERROR, NO_CODE, '0, '0);
						ph = P_DONE;
					end else begin
						ph = P_HEAD;
					end
					acc = '0;
				end
			end
			P_HEAD: begin
				if (pos == 4) begin
					expect_word(ahsp_pkg::KIND_FIELD, ahsp_pkg::FC_VER_MAJOR, 32'(b), '0);
				end else if (pos == 5) begin
					expect_word(ahsp_pkg::KIND_FIELD, ahsp_pkg::FC_VER_MINOR, 32'(b), '0);
				end else if (pos == 6) begin
					acc = 32'(b);
				end else begin
					data_ofs = 16'((acc << 8) | 32'(b));
					acc = '0;
					expect_word(ahsp_pkg::KIND_FIELD, ahsp_pkg::FC_DATA_OFFSET,
						32'(data_ofs), '0);
				end
				pos++;
				if (pos >= 8) begin
					ph = P_TAG;
					tag_cnt = '0;
					check_header_end();
				end
			end
			P_TAG: begin
				acc = (acc << 8) | 32'(b & ahsp_pkg::TAG_MASK);
				pos++;
				tag_cnt++;
				if (tag_cnt >= 4) begin
					word = acc;
					tag_cnt = '0;
					acc = '0;
					if (word == '0) begin
						// A zero tag always closes the header.
						expect_word(ahsp_pkg::KIND_END, NO_CODE, '0, header_file_size());
						ph = P_DONE;
					end else begin
						sect = ahsp_pkg::SK_NONE;
						for (int k = 1; k < 9; k++) begin
							if (ahsp_pkg::TAG_WORDS[k] == word) begin
								sect = 4'(k);
							end
						end
						if (sect != ahsp_pkg::SK_NONE) begin
							ph = P_SECT;
							sect_off = '0;
						end else begin
							check_header_end();
						end
					end
				end
			end
			P_SECT: begin
				acc = (acc << 8) | 32'(b);
				pos++;
				code = ahsp_pkg::SECT_CODE[sect][sect_off];
				if (sect == ahsp_pkg::SK_DEC && sect_off == ahsp_pkg::DEC_SPLIT_OFFSET) begin
					expect_word(ahsp_pkg::KIND_FIELD, ahsp_pkg::FC_DEC_TRACKS,
						32'(b >> 4), '0);
					expect_word(ahsp_pkg::KIND_FIELD, ahsp_pkg::FC_DEC_CHCFG,
						32'(b & ahsp_pkg::NIBBLE), '0);
					acc = '0;
				end else if (code != ahsp_pkg::FC_NONE) begin
					if (code == ahsp_pkg::FC_BLOCK_COUNT) begin
						blocks = acc;
						fmt_seen = 1'b1;
					end else if (code == ahsp_pkg::FC_COMP_BLOCK) begin
						comp_bs = acc[15:0];
						comp_seen = 1'b1;
					end else if (code == ahsp_pkg::FC_DEC_BLOCK) begin
						dec_bs = acc[15:0];
						dec_seen = 1'b1;
					end
					expect_word(ahsp_pkg::KIND_FIELD, code, acc, '0);
					acc = '0;
				end
				sect_off++;
				if (sect_off >= ahsp_pkg::SECT_LEN[sect]) begin
					sect_off = '0;
					sect = ahsp_pkg::SK_NONE;
					ph = P_TAG;
					check_header_end();
				end
			end
			default: begin
			end
		endcase
		if (expected_words.size() > n0) begin
			expected_words[expected_words.size() - 1].last = 1'b1;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fs, input bit drain);
		pending_bytes.push_back('{b, fs, drain});
	endtask

	function automatic logic [7:0] top_bit();
		return 8'($urandom_range(0, 1) << 7);
	endfunction

	// Queues one header: magic, version, offset, sections, optional zero tag and up to three trailing bytes.
	// A negative section count walks every known section once, in order.
	task automatic build_header(input logic [15:0] ofs, input int nsect,
			input bit zero_end, input bit bad_magic);
		logic [31:0] magic;
		logic [7:0]  mb;
		int          bad_at;
		int          kind;
		int          count;
		magic = ahsp_pkg::MAGIC_WORD;
		bad_at = bad_magic ? $urandom_range(0, 3) : -1;
		for (int i = 0; i < 4; i++) begin
			mb = magic[31 - 8 * i -: 8] | top_bit();
			if (i == bad_at) begin
				mb = mb ^ 8'(1 << $urandom_range(0, 6));
			end
			add_byte(mb, i == 0, i == 0 && $urandom_range(0, 9) == 0);
		end
		add_byte(8'($urandom), 1'b0, 1'b0);
		add_byte(8'($urandom), 1'b0, 1'b0);
		add_byte(ofs[15:8], 1'b0, 1'b0);
		add_byte(ofs[7:0], 1'b0, 1'b0);
		count = nsect < 0 ? 8 : nsect;
		for (int s = 0; s < count; s++) begin
			kind = nsect < 0 ? s + 1 : $urandom_range(0, 9);
			if (kind == 0) begin
				// Unknown tag: a first letter below every known one.
				add_byte(8'($urandom_range(1, 8'h5F)) | top_bit(), 1'b0, 1'b0);
				for (int i = 0; i < 3; i++) begin
					add_byte(8'($urandom), 1'b0, 1'b0);
				end
			end else begin
				if (kind == 9) begin
					kind = $urandom_range(1, 8);
				end
				for (int i = 0; i < 4; i++) begin
					add_byte(ahsp_pkg::TAG_WORDS[kind][31 - 8 * i -: 8] | top_bit(),
						1'b0, 1'b0);
				end
				for (int i = 0; i < ahsp_pkg::SECT_LEN[kind]; i++) begin
					add_byte(8'($urandom), 1'b0, 1'b0);
				end
			end
		end
		if (zero_end) begin
			for (int i = 0; i < 4; i++) begin
				add_byte(top_bit(), 1'b0, 1'b0);
			end
		end
		for (int i = $urandom_range(0, 3); i > 0; i--) begin
			add_byte(8'($urandom), 1'b0, 1'b0);
		end
	endtask

	function automatic logic [15:0] pick_offset();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom);
			default: return 16'($urandom_range(8, 120));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	// Driver: predicts each accepted byte, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			data_byte <= '0;
			frame_start <= 1'b0;
		end else begin
			cycle++;
			if (push && !full) begin
				parse_byte(data_byte, frame_start);
			end
			if (!push || !full) begin
				if (pending_bytes.size() > 0 && !idle_now() &&
						!(pending_bytes[0].drain && expected_words.size() > 0)) begin
					push <= 1'b1;
					data_byte <= pending_bytes[0].b;
					frame_start <= pending_bytes[0].fs;
					void'(pending_bytes.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each word taken against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		parse_word_t w;
		if (!arst_n) begin
			pop <= 1'b0;
			stall_cycles = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word kind", 32'(result_kind), '0);
				end else begin
					w = expected_words.pop_front();
					if (result_kind !== w.kind) report_mismatch("kind", 32'(result_kind), 32'(w.kind));
					if (field_code !== w.code) report_mismatch("code", 32'(field_code), 32'(w.code));
					if (field_value !== w.value) report_mismatch("value", field_value, w.value);
					if (file_size !== w.size) report_mismatch("size", file_size, w.size);
					if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
				end
			end
			pop <= !idle_now();
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles = 0;
			end else if (++stall_cycles >= STALL_LIMIT) begin
				$display("audio_header_section_parser_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		clear_parser();
		arst_n = 1'b0;

		// Directed headers: every section, both offset extremes, a bad magic, random
		// sections that may hold unknown tags and a restart part-way through a header.
		build_header(16'd0, -1, 1'b1, 1'b0);
		build_header(16'hFFFF, 2, 1'b1, 1'b0);
		build_header(16'd1, 1, 1'b1, 1'b0);
		build_header(16'd10, 0, 1'b0, 1'b0);
		build_header(16'd40, 3, 1'b0, 1'b1);
		add_byte(8'h48, 1'b1, 1'b1);
		add_byte(8'hC3, 1'b0, 1'b0);
		build_header(16'd30, 2, 1'b0, 1'b0);

		// Random headers, mostly well formed, with some noise between them.
		while (pending_bytes.size() < 320) begin
			if ($urandom_range(0, 9) == 0) begin
				for (int i = $urandom_range(1, 6); i > 0; i--) begin
					add_byte(8'($urandom), 1'($urandom_range(0, 3) == 0), 1'b0);
				end
			end else begin
				build_header(pick_offset(), $urandom_range(0, 5),
					$urandom_range(0, 2) != 0, $urandom_range(0, 9) == 0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || push || expected_words.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("audio_header_section_parser_top verification clean");
		end else begin
			$display("audio_header_section_parser_top verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
